[rtl/core/gsf_pkg.sv]
// Shared types, character codes and check helpers for the sentence framer.
package gsf_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  localparam logic [3:0] XOR_DIGITS = 4'd2;
  localparam logic [3:0] CRC_DIGITS = 4'd8;

  typedef enum logic [1:0] {
    END_OK       = 2'd0,
    END_NO_CHECK = 2'd1,
    END_MISMATCH = 2'd2,
    END_ABORT    = 2'd3
  } end_code_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] payload_byte;
    end_code_t  end_code;
    logic       crc_kind;
    logic [7:0] payload_len;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.value = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.value = 4'(b - 8'h41 + 8'd10);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.value = 4'(b - 8'h61 + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  // Reflected CRC-32, one byte, bitwise.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/core/gsf_in_reg.sv]
// Input register: holds one received byte until the engine takes it.
module gsf_in_reg
  import gsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  assign rx_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!rx_stall) begin
      held_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rx_stall && rx_valid) begin
      held_byte <= rx_byte;
    end
  end

endmodule

[rtl/core/gsf_engine.sv]
// Sentence state machine: framing, running XOR and CRC, check digit compare.
module gsf_engine
  import gsf_pkg::*;
#(
  parameter int MAX_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] byte_in,
  output logic       emit,
  output res_t       res
);

  localparam int CNT_W = $clog2(MAX_BYTES);
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(MAX_BYTES - 2);

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_DATA  = 2'd1,
    PH_CHECK = 2'd2
  } phase_t;

  phase_t           phase, phase_next;
  logic             long_mode, long_mode_next;
  logic [7:0]       xor_sum, xor_sum_next;
  logic [31:0]      crc_run, crc_run_next;
  logic [31:0]      check_rx, check_rx_next;
  logic [3:0]       digit_count, digit_count_next;
  logic [CNT_W-1:0] stored_count, stored_count_next;

  logic  line_end;
  hex_t  hex;
  logic  match;
  logic [3:0] need;

  function automatic logic [7:0] sat_len(input logic [CNT_W-1:0] cnt);
    return (32'(cnt) > 32'd255) ? 8'd255 : 8'(cnt);
  endfunction

  assign line_end = (byte_in == CH_CR) || (byte_in == CH_LF);
  assign hex      = hex_decode(byte_in);
  assign need     = long_mode ? CRC_DIGITS : XOR_DIGITS;

  always_comb begin
    phase_next        = phase;
    long_mode_next    = long_mode;
    xor_sum_next      = xor_sum;
    crc_run_next      = crc_run;
    check_rx_next     = check_rx;
    digit_count_next  = digit_count;
    stored_count_next = stored_count;
    emit              = 1'b0;
    match             = 1'b0;
    res.is_status     = 1'b0;
    res.payload_byte  = 8'd0;
    res.end_code      = END_OK;
    res.crc_kind      = long_mode;
    res.payload_len   = sat_len(stored_count);

    unique case (phase)
      PH_DATA: begin
        if (byte_in == CH_STAR) begin
          phase_next       = PH_CHECK;
          check_rx_next    = 32'd0;
          digit_count_next = 4'd0;
        end else if (line_end) begin
          emit          = 1'b1;
          res.is_status = 1'b1;
          res.end_code  = END_NO_CHECK;
        end else if (stored_count < LIMIT) begin
          stored_count_next = stored_count + CNT_W'(1);
          if (long_mode) begin
            crc_run_next = crc_byte(crc_run, byte_in);
          end else begin
            xor_sum_next = xor_sum ^ byte_in;
          end
          emit             = 1'b1;
          res.payload_byte = byte_in;
          res.payload_len  = sat_len(stored_count_next);
        end
      end
      PH_CHECK: begin
        if (line_end) begin
          emit          = 1'b1;
          res.is_status = 1'b1;
          res.end_code  = END_ABORT;
        end else if (hex.ok) begin
          check_rx_next    = {check_rx[27:0], hex.value};
          digit_count_next = digit_count + 4'd1;
          if (digit_count_next >= need) begin
            match = long_mode ? (check_rx_next == crc_run)
                              : (check_rx_next[7:0] == xor_sum);
            emit          = 1'b1;
            res.is_status = 1'b1;
            res.end_code  = match ? END_OK : END_MISMATCH;
          end
        end
      end
      default: begin
        if (byte_in == CH_DOLLAR || byte_in == CH_HASH) begin
          phase_next        = PH_DATA;
          long_mode_next    = (byte_in == CH_HASH);
          xor_sum_next      = 8'd0;
          crc_run_next      = 32'd0;
          check_rx_next     = 32'd0;
          digit_count_next  = 4'd0;
          stored_count_next = '0;
        end else begin
          phase_next = PH_WAIT;
        end
      end
    endcase

    // close the sentence after any status transaction
    if (emit && res.is_status) begin
      phase_next        = PH_WAIT;
      long_mode_next    = 1'b0;
      xor_sum_next      = 8'd0;
      crc_run_next      = 32'd0;
      check_rx_next     = 32'd0;
      digit_count_next  = 4'd0;
      stored_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WAIT;
      long_mode    <= 1'b0;
      xor_sum      <= 8'd0;
      crc_run      <= 32'd0;
      check_rx     <= 32'd0;
      digit_count  <= 4'd0;
      stored_count <= '0;
    end else if (take) begin
      phase        <= phase_next;
      long_mode    <= long_mode_next;
      xor_sum      <= xor_sum_next;
      crc_run      <= crc_run_next;
      check_rx     <= check_rx_next;
      digit_count  <= digit_count_next;
      stored_count <= stored_count_next;
    end
  end

endmodule

[rtl/core/gsf_out_reg.sv]
// Result register: holds one result transaction until the receiver takes it.
module gsf_out_reg
  import gsf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load_valid,
  input  res_t load_res,
  output logic advance,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  // move on when empty or when the held transaction leaves this cycle
  assign advance = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load_valid) begin
      res <= load_res;
    end
  end

endmodule

[rtl/core/gnss_sentence_framer_checker_top.sv]
// Top level of the GNSS sentence framer and checksum checker.
//
//   channel | ports                                   | dir | one transaction
//   --------+-----------------------------------------+-----+----------------------------
//   rx      | rx_valid, rx_stall, rx_byte             | in  | one received character
//   res     | res_valid, res_stall, is_status,        | out | payload byte or end status
//           | payload_byte, end_code, crc_kind,       |     |
//           | payload_len                             |     |
//
// One byte per cycle sustained while res is not stalled; a byte is held in the input register
// and its result is loaded from there into the result register when that register can advance.
// The per-byte CRC and XOR update is the longest path between the two registers.
// Synchronous reset returns the framer to waiting for a start character.
// A stall on res holds the result register and backs up to rx_stall.
module gnss_sentence_framer_checker_top
  import gsf_pkg::*;
#(
  parameter int MAX_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic       is_status,
  output logic [7:0] payload_byte,
  output logic [1:0] end_code,
  output logic       crc_kind,
  output logic [7:0] payload_len
);

  logic       advance;
  logic       held_valid;
  logic [7:0] held_byte;
  logic       take;
  logic       emit;
  res_t       eng_res;
  res_t       out_res;

  assign take = held_valid && advance;

  gsf_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  gsf_engine #(
    .MAX_BYTES (MAX_BYTES)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .byte_in (held_byte),
    .emit    (emit),
    .res     (eng_res)
  );

  gsf_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load_valid (held_valid && emit),
    .load_res   (eng_res),
    .advance    (advance),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (out_res)
  );

  assign is_status    = out_res.is_status;
  assign payload_byte = out_res.payload_byte;
  assign end_code     = 2'(out_res.end_code);
  assign crc_kind     = out_res.crc_kind;
  assign payload_len  = out_res.payload_len;

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the GNSS sentence framer: predicts each result and compares.
`timescale 1ns / 1ps

module tb_top;
  import gsf_pkg::*;

  localparam int PAYLOAD_CAP = 256 - 2;
  localparam int CYCLE_LIMIT = 200000;

  typedef enum logic [1:0] {FR_WAIT, FR_DATA, FR_CHECK} fr_phase_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic       rx_stall;
  logic [7:0] rx_byte = 8'd0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic       is_status;
  logic [7:0] payload_byte;
  logic [1:0] end_code;
  logic       crc_kind;
  logic [7:0] payload_len;

  gnss_sentence_framer_checker_top DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state
  fr_phase_t   fr_phase = FR_WAIT;
  logic        fr_long = 1'b0;
  logic [7:0]  fr_xor = 8'd0;
  logic [31:0] fr_crc = 32'd0;
  logic [31:0] fr_check = 32'd0;
  logic [3:0]  fr_digits = 4'd0;
  int          fr_stored = 0;

  res_t frame_results_q[$];

  bit gaps_on = 1'b1;
  bit stall_on = 1'b1;
  int err_count = 0;
  int cycles = 0;
  int n_sent = 0;
  int n_payload = 0;
  int n_close[4] = '{0, 0, 0, 0};

  function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] b);
    logic fb;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic bit hex_digit(input logic [7:0] b, output logic [3:0] v);
    v = 4'd0;
    if (b >= "0" && b <= "9") v = 4'(b - "0");
    else if (b >= "A" && b <= "F") v = 4'(b - "A" + 10);
    else if (b >= "a" && b <= "f") v = 4'(b - "a" + 10);
    else return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] n, input bit lower);
    if (n < 10) return 8'("0" + n);
    return lower ? 8'("a" + n - 10) : 8'("A" + n - 10);
  endfunction

  function automatic logic [7:0] safe_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_STAR || b == CH_CR || b == CH_LF);
    return b;
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    logic [3:0] v;
    do b = 8'($urandom); while (hex_digit(b, v) || b == CH_CR || b == CH_LF);
    return b;
  endfunction

  task automatic clear_frame();
    fr_phase  = FR_WAIT;
    fr_long   = 1'b0;
    fr_xor    = 8'd0;
    fr_crc    = 32'd0;
    fr_check  = 32'd0;
    fr_digits = 4'd0;
    fr_stored = 0;
  endtask

  task automatic frame_predict(input logic [7:0] b);
    res_t       r;
    logic [3:0] nib;
    bit         line_end;
    bit         match;
    line_end       = (b == CH_CR) || (b == CH_LF);
    r.is_status    = 1'b0;
    r.payload_byte = 8'd0;
    r.end_code     = END_OK;
    r.crc_kind     = fr_long;
    r.payload_len  = (fr_stored > 255) ? 8'd255 : 8'(fr_stored);
    case (fr_phase)
      FR_DATA: begin
        if (b == CH_STAR) begin
          fr_phase  = FR_CHECK;
          fr_check  = 32'd0;
          fr_digits = 4'd0;
        end else if (line_end) begin
          r.is_status = 1'b1;
          r.end_code  = END_NO_CHECK;
          frame_results_q.push_back(r);
          clear_frame();
        end else if (fr_stored < PAYLOAD_CAP) begin
          fr_stored++;
          if (fr_long) fr_crc = crc32_update(fr_crc, b);
          else fr_xor = fr_xor ^ b;
          r.payload_byte = b;
          r.payload_len  = (fr_stored > 255) ? 8'd255 : 8'(fr_stored);
          frame_results_q.push_back(r);
        end
      end
      FR_CHECK: begin
        if (line_end) begin
          r.is_status = 1'b1;
          r.end_code  = END_ABORT;
          frame_results_q.push_back(r);
          clear_frame();
        end else if (hex_digit(b, nib)) begin
          fr_check = {fr_check[27:0], nib};
          fr_digits++;
          if (fr_digits >= (fr_long ? CRC_DIGITS : XOR_DIGITS)) begin
            match = fr_long ? (fr_check == fr_crc) : (fr_check[7:0] == fr_xor);
            r.is_status = 1'b1;
            r.end_code  = match ? END_OK : END_MISMATCH;
            frame_results_q.push_back(r);
            clear_frame();
          end
        end
      end
      default: begin
        if (b == CH_DOLLAR || b == CH_HASH) begin
          clear_frame();
          fr_phase = FR_DATA;
          fr_long  = (b == CH_HASH);
        end
      end
    endcase
  endtask

  // One transaction on rx; idle cycles carry junk on rx_byte with valid low
  task automatic send_byte(input logic [7:0] b);
    while (gaps_on && $urandom_range(99) < 8) begin
      @(negedge clk);
      rx_valid <= 1'b0;
      rx_byte  <= 8'($urandom);
    end
    @(negedge clk);
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (rx_stall);
    n_sent++;
    frame_predict(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Close the open sentence with '*' and its check digits, optionally corrupted or with noise bytes
  task automatic send_check(input bit corrupt, input bit lower, input bit noisy);
    logic [31:0] val;
    int          nd;
    send_byte(CH_STAR);
    nd  = fr_long ? 8 : 2;
    val = fr_long ? fr_crc : {24'd0, fr_xor};
    if (corrupt) val[$urandom_range(nd * 4 - 1)] ^= 1'b1;
    if (noisy) send_byte(CH_DOLLAR);
    for (int i = nd - 1; i >= 0; i--) begin
      if (noisy && $urandom_range(3) == 0) send_byte(noise_byte());
      send_byte(nibble_char(val[i*4 +: 4], lower));
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    rx_valid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_directed();
    // ignored while waiting for an opener
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_STAR);
    send_byte(CH_CR);
    send_text("$A$#");
    send_check(1'b0, 1'b0, 1'b0);
    send_byte(CH_DOLLAR);
    send_check(1'b0, 1'b1, 1'b0);
    send_text("$Q");
    send_check(1'b1, 1'b0, 1'b1);
    send_text("#GN");
    send_check(1'b0, 1'b1, 1'b1);
    send_text("#Z");
    send_check(1'b1, 1'b0, 1'b0);
    send_text("$ab");
    send_byte(CH_CR);
    send_text("#x*1");
    send_byte(CH_LF);
  endtask

  task automatic test_overflow();
    send_byte(CH_DOLLAR);
    repeat (300) send_byte(safe_byte());
    send_check(1'b0, 1'b0, 1'b0);
    send_byte(CH_HASH);
    repeat (257) send_byte(safe_byte());
    send_check(1'b0, 1'b1, 1'b0);
  endtask

  task automatic test_random_sentences();
    int  body;
    int  pick;
    int  nd;
    bit  paused;
    paused = 1'b0;
    while (n_sent < 1900) begin
      gaps_on  = !(n_sent >= 1000 && n_sent < 1450);
      stall_on = gaps_on;
      // line noise between sentences, which may itself open one
      if ($urandom_range(99) < 15) repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      send_byte($urandom_range(1) ? CH_HASH : CH_DOLLAR);
      pick = $urandom_range(99);
      body = (pick < 3) ? $urandom_range(200, 300) :
             (pick < 12) ? $urandom_range(25, 80) : $urandom_range(0, 24);
      repeat (body) send_byte(safe_byte());
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_check(1'b0, 1'($urandom_range(1)), $urandom_range(3) == 0);
      end else if (pick < 75) begin
        send_check(1'b1, 1'($urandom_range(1)), $urandom_range(3) == 0);
      end else if (pick < 87) begin
        send_byte($urandom_range(1) ? CH_CR : CH_LF);
      end else if (pick < 95) begin
        send_byte(CH_STAR);
        nd = fr_long ? 8 : 2;
        repeat ($urandom_range(nd - 1)) send_byte(nibble_char(4'($urandom), 1'($urandom)));
        send_byte($urandom_range(1) ? CH_CR : CH_LF);
      end
      // otherwise leave the sentence open: the next opener is stored as payload
      if (n_sent >= 1250 && !paused) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  task automatic field_check(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      err_count++;
    end
  endtask

  always @(negedge clk) res_stall <= stall_on && ($urandom_range(99) < 8);

  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (frame_results_q.size() == 0) begin
        $error("result transaction with nothing pending");
        err_count++;
      end else begin
        want = frame_results_q.pop_front();
        field_check("is_status", want.is_status, is_status);
        field_check("payload_byte", want.payload_byte, payload_byte);
        field_check("end_code", want.end_code, end_code);
        field_check("crc_kind", want.crc_kind, crc_kind);
        field_check("payload_len", want.payload_len, payload_len);
        if (want.is_status) n_close[want.end_code]++;
        else n_payload++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    wait_drained();
    test_overflow();
    wait_drained();
    test_random_sentences();
    stall_on = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes; covered %0d payload bytes and %0d sentence ends", n_sent,
             n_payload, n_close[0] + n_close[1] + n_close[2] + n_close[3]);
    $display("Ends: ok %0d, no check %0d, mismatch %0d, aborted %0d",
             n_close[0], n_close[1], n_close[2], n_close[3]);
    if (err_count == 0 && frame_results_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
